FILE: hdl/kchd_pkg.sv
package kchd_pkg;

    localparam int KEY_SLOTS = 8;
    localparam int NUM_KEYS  = 8;
    localparam int TIMER_W   = 16;
    localparam int TICK_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL     = 2'd2;

    localparam logic [TICK_W-1:0]  TICK_PERIOD_RST = 8'd10;
    localparam logic [TIMER_W-1:0] HOLD_THRESH_RST = 16'd1000;
    localparam logic [TIMER_W-1:0] INTERVAL_RST    = 16'd300;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_period;
        logic [TIMER_W-1:0] hold_thresh;
        logic [TIMER_W-1:0] interval;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic up;
        logic dbl;
        logic single;
        logic hold;
        logic pressed;
    } flags_t;

endpackage

FILE: hdl/key_click_hold_detector.sv
// Click, double-click and long-hold detector for up to eight active-low keys.
// Each request carries the sampled pin levels in s_tdata (bit k = key k, 0 =
// pressed) and an operation in s_tuser: 0 is a tick, 1 clears all sticky
// flags. Every request yields one response with six 8-bit sticky flag masks.
// An accepted request is registered, and all keys update in parallel when
// it moves on from the input register, so the block takes one request per
// clock while m_tready stays high; a response is held by the per-key flag
// registers until taken, while the next request waits in the input register.
// Timers count in milliseconds (tick period set by register 0) and saturate
// at 65535. Write configuration only while no request is in flight.
module key_click_hold_detector
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kchd_pkg::KEY_SLOTS-1:0]      s_tdata,   // pin_levels
    input  logic                                s_tuser,   // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pressed_flags, hold_flags, single_click_flags, double_click_flags,
    // up_flags, idle_flags (8 bits each, from bit 0 up)
    output logic [6*kchd_pkg::KEY_SLOTS-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kchd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kchd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    kchd_pkg::cfg_t                   cfg;
    logic                             in_valid_reg, in_valid_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             op_reg;
    logic [kchd_pkg::KEY_SLOTS-1:0]   pins_reg;
    logic                             advance;
    logic                             accept;

    logic [kchd_pkg::KEY_SLOTS-1:0]   pressed;
    logic [kchd_pkg::KEY_SLOTS-1:0]   hold;
    logic [kchd_pkg::KEY_SLOTS-1:0]   single;
    logic [kchd_pkg::KEY_SLOTS-1:0]   dbl;
    logic [kchd_pkg::KEY_SLOTS-1:0]   up;
    logic [kchd_pkg::KEY_SLOTS-1:0]   idle;

    kchd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign accept         = s_tvalid && s_tready;
    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the request until the key stage takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tuser;
            pins_reg <= s_tdata;
        end
    end

    for (genvar k = 0; k < kchd_pkg::KEY_SLOTS; k++)
    begin : g_key
        if (k < kchd_pkg::NUM_KEYS)
        begin : g_used
            kchd_pkg::flags_t key_flags;

            kchd_key u_key
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .step_en (advance),
                .clear   (op_reg == kchd_pkg::OP_CLEAR),
                .pin     (pins_reg[k]),
                .cfg     (cfg),
                .flags   (key_flags)
            );

            assign pressed[k] = key_flags.pressed;
            assign hold[k]    = key_flags.hold;
            assign single[k]  = key_flags.single;
            assign dbl[k]     = key_flags.dbl;
            assign up[k]      = key_flags.up;
            assign idle[k]    = key_flags.idle;
        end
        else
        begin : g_unused
            assign pressed[k] = 1'b0;
            assign hold[k]    = 1'b0;
            assign single[k]  = 1'b0;
            assign dbl[k]     = 1'b0;
            assign up[k]      = 1'b0;
            assign idle[k]    = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {idle, up, dbl, single, hold, pressed};

    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stage refuses a request while empty");

    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("key update did not produce a response");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(m_tdata))
        else $error("flags changed without a key update");

    a_double_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (dbl & ~pressed) == '0)
        else $error("double click flagged without a press");

endmodule

FILE: hdl/kchd_cfg.sv
module kchd_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kchd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kchd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output kchd_pkg::cfg_t                      cfg
);

    kchd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_period <= kchd_pkg::TICK_PERIOD_RST;
            cfg_reg.hold_thresh <= kchd_pkg::HOLD_THRESH_RST;
            cfg_reg.interval    <= kchd_pkg::INTERVAL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                kchd_pkg::REG_TICK_PERIOD:
                    cfg_reg.tick_period <= cfg_data[kchd_pkg::TICK_W-1:0];
                kchd_pkg::REG_HOLD_THRESH:
                    cfg_reg.hold_thresh <= cfg_data;
                kchd_pkg::REG_INTERVAL:
                    cfg_reg.interval    <= cfg_data;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

FILE: hdl/kchd_key.sv
module kchd_key
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic              clear,
    input  logic              pin,
    input  kchd_pkg::cfg_t    cfg,
    output kchd_pkg::flags_t  flags
);

    typedef enum logic [1:0]
    {
        CLICK_NONE   = 2'd0,
        CLICK_SINGLE = 2'd1,
        CLICK_DOUBLE = 2'd2
    } click_t;

    logic                          level_reg, level_next;
    logic [kchd_pkg::TIMER_W-1:0]  hold_reg, hold_next;
    logic [kchd_pkg::TIMER_W-1:0]  gap_reg, gap_next;
    logic                          pend_reg, pend_next;
    logic                          pressed_reg, pressed_next;
    logic                          hold_flag_reg, hold_flag_next;
    logic                          dbl_reg, dbl_next;
    logic                          up_reg, up_next;
    logic                          idle_reg, idle_next;
    click_t                        click_reg, click_next;

    logic [kchd_pkg::TIMER_W:0]    hold_sum;
    logic [kchd_pkg::TIMER_W:0]    gap_sum;
    logic [kchd_pkg::TIMER_W-1:0]  hold_sat;
    logic [kchd_pkg::TIMER_W-1:0]  gap_sat;

    assign hold_sum = {1'b0, hold_reg}
                    + {{(kchd_pkg::TIMER_W + 1 - kchd_pkg::TICK_W){1'b0}}, cfg.tick_period};
    assign gap_sum  = {1'b0, gap_reg}
                    + {{(kchd_pkg::TIMER_W + 1 - kchd_pkg::TICK_W){1'b0}}, cfg.tick_period};
    assign hold_sat = hold_sum[kchd_pkg::TIMER_W] ? '1 : hold_sum[kchd_pkg::TIMER_W-1:0];
    assign gap_sat  = gap_sum[kchd_pkg::TIMER_W]  ? '1 : gap_sum[kchd_pkg::TIMER_W-1:0];

    always_comb
    begin
        level_next     = level_reg;
        hold_next      = hold_reg;
        gap_next       = gap_reg;
        pend_next      = pend_reg;
        pressed_next   = pressed_reg;
        hold_flag_next = hold_flag_reg;
        dbl_next       = dbl_reg;
        up_next        = up_reg;
        idle_next      = idle_reg;
        click_next     = click_reg;

        if (clear)
        begin
            pressed_next   = 1'b0;
            hold_flag_next = 1'b0;
            dbl_next       = 1'b0;
            up_next        = 1'b0;
            idle_next      = 1'b0;
            click_next     = CLICK_NONE;
        end
        else
        begin
            level_next = pin;
            priority if (level_reg && !pin)
            begin
                pressed_next = 1'b1;
                hold_next    = '0;
                if (!pend_reg)
                begin
                    click_next = CLICK_SINGLE;
                    pend_next  = 1'b1;
                end
                else if (gap_reg <= cfg.interval)
                begin
                    dbl_next   = 1'b1;
                    click_next = CLICK_DOUBLE;
                    pend_next  = 1'b0;
                end
            end
            else if (!level_reg && pin)
            begin
                up_next = 1'b1;
                if (pend_reg)
                begin
                    gap_next = '0;
                end
            end
            else if (!pin)
            begin
                hold_next = hold_sat;
                if (hold_sat >= cfg.hold_thresh)
                begin
                    hold_flag_next = 1'b1;
                    pend_next      = 1'b0;
                end
            end
            else
            begin
                idle_next = 1'b1;
                if (pend_reg)
                begin
                    if (gap_sat > cfg.interval)
                    begin
                        pend_next = 1'b0;
                        gap_next  = '0;
                    end
                    else
                    begin
                        gap_next = gap_sat;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 1'b1;
            hold_reg      <= '0;
            gap_reg       <= '0;
            pend_reg      <= 1'b0;
            pressed_reg   <= 1'b0;
            hold_flag_reg <= 1'b0;
            dbl_reg       <= 1'b0;
            up_reg        <= 1'b0;
            idle_reg      <= 1'b0;
            click_reg     <= CLICK_NONE;
        end
        else if (step_en)
        begin
            level_reg     <= level_next;
            hold_reg      <= hold_next;
            gap_reg       <= gap_next;
            pend_reg      <= pend_next;
            pressed_reg   <= pressed_next;
            hold_flag_reg <= hold_flag_next;
            dbl_reg       <= dbl_next;
            up_reg        <= up_next;
            idle_reg      <= idle_next;
            click_reg     <= click_next;
        end
    end

    always_comb
    begin
        flags.pressed = pressed_reg;
        flags.hold    = hold_flag_reg;
        flags.dbl     = dbl_reg;
        flags.up      = up_reg;
        flags.idle    = idle_reg;
        unique case (click_reg)
            CLICK_SINGLE: flags.single = 1'b1;
            default:      flags.single = 1'b0;
        endcase
    end

endmodule

FILE: tb/key_click_hold_detector_tb.sv
module key_click_hold_detector_tb;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_STALL    = 80;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RUN_CAP       = 120;

    localparam logic [kchd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef logic [kchd_pkg::KEY_SLOTS-1:0]  pins_t;
    typedef logic [kchd_pkg::CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [kchd_pkg::TICK_W-1:0]     tick_t;

    typedef enum logic [1:0]
    {
        CLICK_NONE,
        CLICK_SINGLE,
        CLICK_DOUBLE
    } click_state_t;

    // Field order matches m_tdata, pressed in the lowest byte.
    typedef struct packed
    {
        logic [kchd_pkg::KEY_SLOTS-1:0] idle;
        logic [kchd_pkg::KEY_SLOTS-1:0] up;
        logic [kchd_pkg::KEY_SLOTS-1:0] dbl;
        logic [kchd_pkg::KEY_SLOTS-1:0] single;
        logic [kchd_pkg::KEY_SLOTS-1:0] hold;
        logic [kchd_pkg::KEY_SLOTS-1:0] pressed;
    } key_masks_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [kchd_pkg::KEY_SLOTS-1:0]       s_tdata = '1;
    logic                                 s_tuser = kchd_pkg::OP_TICK;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [6*kchd_pkg::KEY_SLOTS-1:0]     m_tdata;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [kchd_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [kchd_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    logic [kchd_pkg::TICK_W-1:0]          tick_ms = kchd_pkg::TICK_PERIOD_RST;
    logic [kchd_pkg::TIMER_W-1:0]         hold_limit_ms = kchd_pkg::HOLD_THRESH_RST;
    logic [kchd_pkg::TIMER_W-1:0]         gap_limit_ms = kchd_pkg::INTERVAL_RST;
    logic                                 key_level [kchd_pkg::NUM_KEYS] = '{default: 1'b1};
    logic [kchd_pkg::TIMER_W-1:0]         held_ms [kchd_pkg::NUM_KEYS] = '{default: '0};
    logic [kchd_pkg::TIMER_W-1:0]         gap_ms [kchd_pkg::NUM_KEYS] = '{default: '0};
    logic                                 awaiting_second [kchd_pkg::NUM_KEYS] =
                                              '{default: 1'b0};
    click_state_t                         click_state [kchd_pkg::NUM_KEYS] =
                                              '{default: CLICK_NONE};
    logic [kchd_pkg::KEY_SLOTS-1:0]       seen_press = '0;
    logic [kchd_pkg::KEY_SLOTS-1:0]       seen_hold = '0;
    logic [kchd_pkg::KEY_SLOTS-1:0]       seen_double = '0;
    logic [kchd_pkg::KEY_SLOTS-1:0]       seen_up = '0;
    logic [kchd_pkg::KEY_SLOTS-1:0]       seen_idle = '0;

    key_masks_t                 expected_masks [$];
    int                         cycle_count = 0;
    int                         mismatches = 0;
    bit                         sender_idles = 1'b1;
    bit                         receiver_idles = 1'b1;
    int                         long_stalls_asked = 0;
    int                         long_stalls_done = 0;
    int                         stall_left = 0;

    key_click_hold_detector i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("key_click_hold_detector: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (long_stalls_done != long_stalls_asked)
        begin
            long_stalls_done = long_stalls_asked;
            stall_left = LONG_STALL;
        end
        else if (stall_left == 0 && receiver_idles && $urandom_range(0, 99) < 20)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(1, 3);
        end
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_mask(string name, pins_t exp_mask, pins_t got_mask);
        if (got_mask !== exp_mask)
        begin
            $error("%s: expected %02h, got %02h", name, exp_mask, got_mask);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_responses
        key_masks_t exp_m;
        key_masks_t got_m;
        if (m_tvalid && m_tready)
        begin
            if (expected_masks.size() == 0)
            begin
                $error("response with no request outstanding: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                exp_m = expected_masks.pop_front();
                got_m = m_tdata;
                check_mask("pressed_flags", exp_m.pressed, got_m.pressed);
                check_mask("hold_flags", exp_m.hold, got_m.hold);
                check_mask("single_click_flags", exp_m.single, got_m.single);
                check_mask("double_click_flags", exp_m.dbl, got_m.dbl);
                check_mask("up_flags", exp_m.up, got_m.up);
                check_mask("idle_flags", exp_m.idle, got_m.idle);
            end
        end
    end

    function automatic logic [kchd_pkg::TIMER_W-1:0] sat_ms(
        logic [kchd_pkg::TIMER_W-1:0] acc,
        logic [kchd_pkg::TICK_W-1:0]  step);
        logic [kchd_pkg::TIMER_W:0] sum;
        sum = {1'b0, acc}
            + {{(kchd_pkg::TIMER_W + 1 - kchd_pkg::TICK_W){1'b0}}, step};
        return sum[kchd_pkg::TIMER_W] ? '1 : sum[kchd_pkg::TIMER_W-1:0];
    endfunction

    function automatic void advance_keys(logic op, pins_t pins);
        key_masks_t m;
        m = '0;
        for (int k = 0; k < kchd_pkg::NUM_KEYS; k++)
        begin
            if (op == kchd_pkg::OP_CLEAR)
            begin
                seen_press[k]  = 1'b0;
                seen_hold[k]   = 1'b0;
                seen_double[k] = 1'b0;
                seen_up[k]     = 1'b0;
                seen_idle[k]   = 1'b0;
                click_state[k] = CLICK_NONE;
            end
            else
            begin
                if (key_level[k] && !pins[k])
                begin
                    seen_press[k] = 1'b1;
                    held_ms[k] = '0;
                    if (!awaiting_second[k])
                    begin
                        click_state[k] = CLICK_SINGLE;
                        awaiting_second[k] = 1'b1;
                    end
                    else if (gap_ms[k] <= gap_limit_ms)
                    begin
                        seen_double[k] = 1'b1;
                        click_state[k] = CLICK_DOUBLE;
                        awaiting_second[k] = 1'b0;
                    end
                end
                else if (!key_level[k] && pins[k])
                begin
                    seen_up[k] = 1'b1;
                    if (awaiting_second[k])
                        gap_ms[k] = '0;
                end
                else if (!pins[k])
                begin
                    held_ms[k] = sat_ms(held_ms[k], tick_ms);
                    if (held_ms[k] >= hold_limit_ms)
                    begin
                        seen_hold[k] = 1'b1;
                        awaiting_second[k] = 1'b0;
                    end
                end
                else
                begin
                    seen_idle[k] = 1'b1;
                    if (awaiting_second[k])
                    begin
                        gap_ms[k] = sat_ms(gap_ms[k], tick_ms);
                        if (gap_ms[k] > gap_limit_ms)
                        begin
                            awaiting_second[k] = 1'b0;
                            gap_ms[k] = '0;
                        end
                    end
                end
                key_level[k] = pins[k];
            end
            m.pressed[k] = seen_press[k];
            m.hold[k]    = seen_hold[k];
            m.single[k]  = (click_state[k] == CLICK_SINGLE);
            m.dbl[k]     = seen_double[k];
            m.up[k]      = seen_up[k];
            m.idle[k]    = seen_idle[k];
        end
        expected_masks.push_back(m);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(input logic op, input pins_t pins);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= pins;
        do
            @(posedge clk);
        while (!s_tready);
        advance_keys(op, pins);
    endtask

    task automatic wait_for_responses();
        s_tvalid <= 1'b0;
        while (expected_masks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [kchd_pkg::CFG_IDX_W-1:0] idx,
                             input cfg_word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            kchd_pkg::REG_TICK_PERIOD: tick_ms = data[kchd_pkg::TICK_W-1:0];
            kchd_pkg::REG_HOLD_THRESH: hold_limit_ms = data;
            kchd_pkg::REG_INTERVAL:    gap_limit_ms = data;
            default:                   ;
        endcase
    endtask

    task automatic configure(input cfg_word_t tick_data,
                             input cfg_word_t hold,
                             input cfg_word_t interval,
                             input bit poke_spare);
        wait_for_responses();
        write_reg(kchd_pkg::REG_TICK_PERIOD, tick_data);
        write_reg(kchd_pkg::REG_HOLD_THRESH, hold);
        write_reg(kchd_pkg::REG_INTERVAL, interval);
        if (poke_spare)
            write_reg(REG_SPARE, cfg_word_t'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_config();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        send_request(kchd_pkg::OP_TICK, 8'hFF);
        send_request(kchd_pkg::OP_TICK, 8'h00);
        send_request(kchd_pkg::OP_TICK, 8'hFF);
        send_request(kchd_pkg::OP_TICK, 8'h00);
        send_request(kchd_pkg::OP_CLEAR, 8'hA5);
        send_request(kchd_pkg::OP_TICK, 8'h00);
        send_request(kchd_pkg::OP_TICK, 8'hFF);
    endtask

    // key 0 holds until its timer saturates, key 1 waits out a saturated gap
    task automatic test_timer_saturation();
        configure(16'd255, 16'hFFFF, 16'hFFFF, 1'b0);
        send_request(kchd_pkg::OP_TICK, 8'hFC);
        send_request(kchd_pkg::OP_TICK, 8'hFE);
        repeat (260) send_request(kchd_pkg::OP_TICK, 8'hFE);
        send_request(kchd_pkg::OP_TICK, 8'hFC);
        send_request(kchd_pkg::OP_TICK, 8'hFF);
    endtask

    task automatic test_hold_threshold();
        configure(16'hFFFF, 16'd500, 16'd1, 1'b0);
        send_request(kchd_pkg::OP_TICK, 8'hF0);
        send_request(kchd_pkg::OP_TICK, 8'hF0);
        send_request(kchd_pkg::OP_TICK, 8'hF0);
        send_request(kchd_pkg::OP_TICK, 8'hFF);
    endtask

    task automatic test_zero_settings();
        configure(16'hAB00, 16'd0, 16'd0, 1'b1);
        send_request(kchd_pkg::OP_TICK, 8'hFF);
        send_request(kchd_pkg::OP_TICK, 8'h00);
        send_request(kchd_pkg::OP_TICK, 8'h00);
        send_request(kchd_pkg::OP_TICK, 8'hFF);
        send_request(kchd_pkg::OP_TICK, 8'h00);
        send_request(kchd_pkg::OP_TICK, 8'hFF);
        send_request(kchd_pkg::OP_TICK, 8'hFF);
        send_request(kchd_pkg::OP_TICK, 8'h00);
    endtask

    task automatic test_output_backpressure();
        configure(16'd10, 16'd40, 16'd30, 1'b0);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        long_stalls_asked++;
        repeat (40) send_request(kchd_pkg::OP_TICK, pins_t'($urandom_range(0, 255)));
        wait_for_responses();
    endtask

    task automatic test_random_traffic(input int n,
                                       input cfg_word_t tick_data,
                                       input cfg_word_t hold,
                                       input cfg_word_t interval,
                                       input bit idles);
        pins_t levels;
        int run_left [kchd_pkg::NUM_KEYS];
        int tick_eff;
        int short_max;
        int long_max;
        int r;
        configure(tick_data, hold, interval, 1'b0);
        sender_idles = idles;
        receiver_idles = idles;
        tick_eff = (tick_data[kchd_pkg::TICK_W-1:0] == 0) ? 1
                 : int'(tick_data[kchd_pkg::TICK_W-1:0]);
        short_max = int'(interval) / tick_eff + 2;
        long_max = int'(hold) / tick_eff + 3;
        if (short_max > RUN_CAP)
            short_max = RUN_CAP;
        if (long_max > RUN_CAP)
            long_max = RUN_CAP;
        levels = '1;
        foreach (run_left[k])
            run_left[k] = $urandom_range(1, short_max);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_request(kchd_pkg::OP_CLEAR, pins_t'($urandom_range(0, 255)));
            else if (r < 12)
                send_request(kchd_pkg::OP_TICK, pins_t'($urandom_range(0, 255)));
            else
            begin
                for (int k = 0; k < kchd_pkg::NUM_KEYS; k++)
                begin
                    if (run_left[k] == 0)
                    begin
                        levels[k] = ~levels[k];
                        run_left[k] = ($urandom_range(0, 2) == 0) ?
                                      $urandom_range(1, long_max) :
                                      $urandom_range(1, short_max);
                    end
                    run_left[k]--;
                end
                send_request(kchd_pkg::OP_TICK, levels);
            end
        end
    endtask

    initial
    begin
        tick_t rnd_tick;
        cfg_word_t rnd_hold;
        cfg_word_t rnd_interval;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_default_config();
        test_timer_saturation();
        test_hold_threshold();
        test_zero_settings();
        test_output_backpressure();
        test_random_traffic(100, 16'd10, 16'd1000, 16'd300, 1'b1);
        test_random_traffic(80, 16'd1, 16'd1, 16'd1, 1'b0);
        test_random_traffic(80, 16'd255, 16'hFFFF, 16'hFFFF, 1'b1);
        test_random_traffic(120, 16'd10, 16'd200, 16'd50, 1'b1);
        rnd_tick = tick_t'($urandom_range(1, 255));
        rnd_hold = cfg_word_t'($urandom_range(1, int'(rnd_tick) * 40));
        rnd_interval = cfg_word_t'($urandom_range(1, int'(rnd_tick) * 12));
        test_random_traffic(100, {8'h00, rnd_tick}, rnd_hold, rnd_interval, 1'b1);
        test_random_traffic(70, 16'd200, 16'd800, 16'd600, 1'b0);
        wait_for_responses();
        if (mismatches == 0)
            $display("key_click_hold_detector: match");
        else
            $display("key_click_hold_detector: mismatch");
        $finish;
    end

endmodule
